// ===== hw/rtl/gfq_polynomial_multipoint_eval_macros.svh =====
// ----------------------------------------------------------------------------
// gfq_polynomial_multipoint_eval_macros
// Assertion macros for the multipoint evaluator, clocked on clk, reset on arst_n.
// ----------------------------------------------------------------------------
`ifndef GFQ_POLYNOMIAL_MULTIPOINT_EVAL_MACROS_SVH
`define GFQ_POLYNOMIAL_MULTIPOINT_EVAL_MACROS_SVH

// check a consequent in the same cycle
`define GQE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequent in the next cycle
`define GQE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqe_pkg
// Shared constants, types and the evaluation weight function.
// ----------------------------------------------------------------------------
package gqe_pkg;

	localparam int NUM_COEFS         = 10;
	localparam int VAL_W             = 7;
	localparam int SLOT_W            = 5;
	localparam int NUM_SLOTS         = 19;
	localparam int LAST_SLOT_SHORT   = 4;
	localparam int LAST_SLOT_LONG    = 18;
	localparam int LEAD_SHORT        = 2;
	localparam int LEAD_LONG         = 9;
	localparam int SLOT_LAST_FINITE  = 17;
	localparam int LAST_FINITE_POINT = 9;
	localparam int QUEUE_DEPTH       = 2;
	localparam int MODULUS_DEFAULT   = 127;

	typedef enum logic {
		MODE_SHORT = 1'b0,
		MODE_LONG  = 1'b1
	} cmode_t;

	typedef struct packed {
		logic [NUM_COEFS-1:0][VAL_W-1:0] coef;
		logic                            column_end;
		cmode_t                          mode;
		logic [SLOT_W-1:0]               last_slot;
	} entry_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} qstat_t;

	// weight of coefficient k for a given slot: point^k mod m, or the leading-term pick
	function automatic logic [VAL_W-1:0] weight_f(input logic mode, input int slot,
		input int k, input int m);
		int t;
		int lead;
		int w;
		int acc;
		bit at_inf;
		t      = 0;
		lead   = LEAD_LONG;
		at_inf = 1'b0;
		if (mode == MODE_SHORT) begin
			lead   = LEAD_SHORT;
			at_inf = (slot == LAST_SLOT_SHORT);
			case (slot)
				0:       t = 0;
				1:       t = 1;
				2:       t = m - 1;
				default: t = 2;
			endcase
		end else begin
			at_inf = (slot == LAST_SLOT_LONG);
			if (slot == 0) begin
				t = 0;
			end else if (slot == SLOT_LAST_FINITE) begin
				t = LAST_FINITE_POINT;
			end else if (slot[0]) begin
				t = (slot + 1) >> 1;
			end else begin
				t = m - (slot >> 1);
			end
		end
		if (k > lead) begin
			return '0;
		end
		if (at_inf) begin
			return (k == lead) ? VAL_W'(1) : VAL_W'(0);
		end
		w = 1;
		for (int i = 0; i < NUM_COEFS; i++) begin
			if (i < k) begin
				acc = 0;
				for (int j = 0; j < (1 << VAL_W); j++) begin
					if (j < t) begin
						acc = acc + w;
						if (acc >= m) begin
							acc = acc - m;
						end
					end
				end
				w = acc;
			end
		end
		return w[VAL_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/gqe_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqe_channels
// Valid/ready channels: coefficient columns, point results, mode writes.
// ----------------------------------------------------------------------------
interface gqe_col_if;
	logic                    valid;
	logic                    ready;
	logic [gqe_pkg::VAL_W-1:0] coef_0;
	logic [gqe_pkg::VAL_W-1:0] coef_1;
	logic [gqe_pkg::VAL_W-1:0] coef_2;
	logic [gqe_pkg::VAL_W-1:0] coef_3;
	logic [gqe_pkg::VAL_W-1:0] coef_4;
	logic [gqe_pkg::VAL_W-1:0] coef_5;
	logic [gqe_pkg::VAL_W-1:0] coef_6;
	logic [gqe_pkg::VAL_W-1:0] coef_7;
	logic [gqe_pkg::VAL_W-1:0] coef_8;
	logic [gqe_pkg::VAL_W-1:0] coef_9;
	logic                    column_end;

	modport source (output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6,
		coef_7, coef_8, coef_9, column_end, input ready);
	modport sink (input valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6,
		coef_7, coef_8, coef_9, column_end, output ready);
endinterface

interface gqe_pt_if;
	logic                       valid;
	logic                       ready;
	logic [gqe_pkg::VAL_W-1:0]  point_value;
	logic [gqe_pkg::SLOT_W-1:0] point_slot;
	logic                       final_point;
	logic                       batch_end;

	modport source (output valid, point_value, point_slot, final_point, batch_end,
		input ready);
	modport sink (input valid, point_value, point_slot, final_point, batch_end,
		output ready);
endinterface

interface gqe_cfg_if;
	logic valid;
	logic ready;
	logic coefficient_mode;

	modport source (output valid, coefficient_mode, input ready);
	modport sink (input valid, coefficient_mode, output ready);
endinterface

// ===== hw/rtl/gqe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqe_front
// Accept columns, hold the mode register and tag each word for the queue.
// ----------------------------------------------------------------------------
module gqe_front (
	input  logic            clk,
	input  logic            arst_n,
	gqe_col_if.sink         col,
	gqe_cfg_if.sink         cfg,
	input  gqe_pkg::qstat_t qstat,
	output logic            push,
	output gqe_pkg::entry_t push_entry
);

	gqe_pkg::cmode_t mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gqe_pkg::MODE_LONG;
		end else if (cfg.valid) begin
			mode_q <= gqe_pkg::cmode_t'(cfg.coefficient_mode);
		end
	end

	assign col.ready = !qstat.full;
	assign push      = col.valid && !qstat.full;

	always_comb begin
		push_entry.coef[0]    = col.coef_0;
		push_entry.coef[1]    = col.coef_1;
		push_entry.coef[2]    = col.coef_2;
		push_entry.coef[3]    = col.coef_3;
		push_entry.coef[4]    = col.coef_4;
		push_entry.coef[5]    = col.coef_5;
		push_entry.coef[6]    = col.coef_6;
		push_entry.coef[7]    = col.coef_7;
		push_entry.coef[8]    = col.coef_8;
		push_entry.coef[9]    = col.coef_9;
		push_entry.column_end = col.column_end;
		push_entry.mode       = mode_q;
		// classify: last slot of the word
		if (mode_q == gqe_pkg::MODE_LONG) begin
			push_entry.last_slot = gqe_pkg::SLOT_W'(gqe_pkg::LAST_SLOT_LONG);
		end else begin
			push_entry.last_slot = gqe_pkg::SLOT_W'(gqe_pkg::LAST_SLOT_SHORT);
		end
	end

endmodule

// ===== hw/rtl/gqe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqe_queue
// Short word queue between the front and the evaluation pipeline.
// ----------------------------------------------------------------------------
module gqe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gqe_pkg::entry_t push_entry,
	input  logic            pop,
	output gqe_pkg::entry_t head,
	output gqe_pkg::qstat_t qstat
);

	localparam int DEPTH = gqe_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gqe_pkg::entry_t   slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head             = slots_q[rd_ptr_q];
	assign qstat.head_valid = (count_q != '0);
	assign qstat.full       = (count_q == CNT_W'(DEPTH));

endmodule

// ===== hw/rtl/gqe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqe_back
// Slot sequencer and four-stage weighted-sum evaluator with modular reduction.
// ----------------------------------------------------------------------------
module gqe_back #(
	parameter int MODULUS = gqe_pkg::MODULUS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gqe_pkg::entry_t head,
	input  gqe_pkg::qstat_t qstat,
	output logic            pop,
	gqe_pt_if.source        pt
);

	localparam int VAL_W  = gqe_pkg::VAL_W;
	localparam int SLOT_W = gqe_pkg::SLOT_W;
	localparam int NCOEF  = gqe_pkg::NUM_COEFS;
	localparam int NSLOT  = gqe_pkg::NUM_SLOTS;
	localparam int PROD_W = 2 * VAL_W;
	localparam int SUM_W  = PROD_W + $clog2(NCOEF);
	localparam int QHAT_W = SUM_W - $clog2(MODULUS) + 1;
	localparam logic [QHAT_W-1:0] RECIP = QHAT_W'((1 << SUM_W) / MODULUS);

	logic [VAL_W-1:0] weight_tab [2][NSLOT][NCOEF];

	for (genvar md = 0; md < 2; md++) begin : g_mode
		for (genvar sl = 0; sl < NSLOT; sl++) begin : g_slot
			for (genvar k = 0; k < NCOEF; k++) begin : g_coef
				assign weight_tab[md][sl][k] = gqe_pkg::weight_f(1'(md), sl, k, MODULUS);
			end
		end
	end

	logic                     adv;
	logic                     issue;
	logic                     last_of_word;
	logic [SLOT_W-1:0]        slot_q;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [PROD_W-1:0]        prod_s1 [NCOEF];
	logic [SLOT_W-1:0]        slot_s1, slot_s2, slot_s3, slot_s4;
	logic                     fin_s1, fin_s2, fin_s3, fin_s4;
	logic                     end_s1, end_s2, end_s3, end_s4;
	logic [SUM_W-1:0]         sum_s2, sum_s3;
	logic [QHAT_W-1:0]        qhat_s3;
	logic [VAL_W-1:0]         val_s4;

	logic [SUM_W-1:0]         sum_c;
	logic [SUM_W+QHAT_W-1:0]  qprod_c;
	logic [SUM_W-1:0]         diff_c;
	logic [VAL_W:0]           rem_c;
	logic [VAL_W-1:0]         val_c;

	// advance the whole pipe unless the output word is held
	assign adv          = !v_s4 || pt.ready;
	assign issue        = qstat.head_valid && adv;
	assign last_of_word = (slot_q == head.last_slot);
	assign pop          = issue && last_of_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			if (issue) begin
				slot_q <= last_of_word ? '0 : slot_q + SLOT_W'(1);
			end
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < NCOEF; k++) begin
			sum_c = sum_c + SUM_W'(prod_s1[k]);
		end
		qprod_c = (SUM_W+QHAT_W)'(sum_s2) * (SUM_W+QHAT_W)'(RECIP);
		diff_c  = sum_s3 - SUM_W'(SUM_W'(qhat_s3) * SUM_W'(MODULUS));
		rem_c   = diff_c[VAL_W:0];
		if (rem_c >= (VAL_W+1)'(MODULUS)) begin
			val_c = VAL_W'(rem_c - (VAL_W+1)'(MODULUS));
		end else begin
			val_c = rem_c[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NCOEF; k++) begin
				prod_s1[k] <= PROD_W'(head.coef[k]) *
					PROD_W'(weight_tab[head.mode][slot_q][k]);
			end
			slot_s1 <= slot_q;
			fin_s1  <= last_of_word;
			end_s1  <= head.column_end;

			sum_s2  <= sum_c;
			slot_s2 <= slot_s1;
			fin_s2  <= fin_s1;
			end_s2  <= end_s1;

			sum_s3  <= sum_s2;
			qhat_s3 <= qprod_c[SUM_W+QHAT_W-1:SUM_W];
			slot_s3 <= slot_s2;
			fin_s3  <= fin_s2;
			end_s3  <= end_s2;

			val_s4  <= val_c;
			slot_s4 <= slot_s3;
			fin_s4  <= fin_s3;
			end_s4  <= end_s3;
		end
	end

	assign pt.valid       = v_s4;
	assign pt.point_value = val_s4;
	assign pt.point_slot  = slot_s4;
	assign pt.final_point = fin_s4;
	assign pt.batch_end   = end_s4;

endmodule

// ===== hw/rtl/gfq_polynomial_multipoint_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfq_polynomial_multipoint_eval
// Multipoint evaluation of a coefficient column over GF(MODULUS).
// ----------------------------------------------------------------------------
// Each accepted column yields one result word per cycle on the point channel while it is not
// held by point.ready: five words (slots 0..4) in three-coefficient mode, nineteen (slots 0..18)
// in ten-coefficient mode, so the slot sequencer sets the sustained rate. After the column
// reaches the head of the two-word queue, its first point passes the product, sum,
// quotient and result registers; the queue takes new columns while earlier ones are still evaluated.
// Every point is a weighted sum of the coefficients with constant power weights, reduced
// modulo MODULUS by a reciprocal multiply and one correction. The mode register resets to
// ten-coefficient mode. The user must write it only while the block is idle; the block does not enforce it.
module gfq_polynomial_multipoint_eval #(
	parameter int MODULUS = gqe_pkg::MODULUS_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	gqe_col_if.sink  column,
	gqe_pt_if.source point,
	gqe_cfg_if.sink  cfg
);

	`include "gfq_polynomial_multipoint_eval_macros.svh"

	logic            push;
	logic            pop;
	gqe_pkg::entry_t push_entry;
	gqe_pkg::entry_t head;
	gqe_pkg::qstat_t qstat;

	gqe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.col        (column),
		.cfg        (cfg),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	gqe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	gqe_back #(
		.MODULUS (MODULUS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.pt     (point)
	);

	`GQE_ASSERT_NOW(a_final_slot, point.valid && point.final_point, point.point_slot == gqe_pkg::SLOT_W'(gqe_pkg::LAST_SLOT_SHORT) || point.point_slot == gqe_pkg::SLOT_W'(gqe_pkg::LAST_SLOT_LONG), "final point on a non-final slot")
	`GQE_ASSERT_NOW(a_value_range, point.valid, point.point_value < gqe_pkg::VAL_W'(MODULUS), "point value not reduced")
	`GQE_ASSERT_NOW(a_stall_cause, column.valid && !column.ready, qstat.head_valid, "column refused with an empty queue")
	`GQE_ASSERT_NEXT(a_push_held, column.valid && column.ready && !pop, qstat.head_valid, "pushed word lost from the queue")

endmodule
